@@ design/assert_macros.svh @@
// assertion macros shared by the checker files
// depends on clock and reset names in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property, off during reset
`define SPCS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("spcs assertion failed");

// implication form
`define SPCS_ASSERT_IMP(label, ante, cons) \
   `SPCS_ASSERT(label, (ante) |-> (cons))

// next-cycle implication form
`define SPCS_ASSERT_NXT(label, ante, cons) \
   `SPCS_ASSERT(label, (ante) |=> (cons))

`endif

@@ design/spcs_pkg.sv @@
// constants shared by the segmented prime count sieve
// no dependencies
`default_nettype none

package spcs_pkg;

   localparam int unsigned LIMIT_W = 21;
   localparam int unsigned COUNT_W = 17;
   localparam int unsigned REQ_W   = 24;
   localparam int unsigned RSP_W   = 24;

   // working width for numbers and next multiples, kept even for the root unit
   localparam int unsigned NUM_W = 22;

   localparam longint unsigned SPCS_MAX_LIMIT       = 64'd1048576;
   localparam int unsigned     SPCS_WINDOW_SIZE     = 1024;
   localparam int unsigned     SPCS_MAX_BASE_PRIMES = 256;

endpackage

`default_nettype wire

@@ design/spcs_isqrt.sv @@
// iterative exact integer square root, one result bit per cycle
// depends on spcs_pkg
`default_nettype none

module spcs_isqrt
   import spcs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] value,
   output logic                  done,
   output logic [NUM_W-1:0]      root
);

   logic [NUM_W-1:0] v_ff, v_in;
   logic [NUM_W-1:0] r_ff, r_in;
   logic [NUM_W-1:0] bit_ff, bit_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [NUM_W-1:0] sum;

   always_comb begin
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sum     = r_ff + bit_ff;
      if (start) begin
         v_in    = value;
         r_in    = '0;
         bit_in  = NUM_W'(1) << (NUM_W - 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= sum) begin
            v_in = v_ff - sum;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == NUM_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff;

endmodule

`default_nettype wire

@@ design/segmented_prime_count_sieve.sv @@
// segmented prime count sieve, top level; depends on spcs_pkg and spcs_isqrt
// a beat on req carries a limit n; one beat on rsp returns the count of primes <= n
// req_tready is high only while the block is idle; one limit is worked at a time
// limits above the supported range are clamped, limits below 2 answer 0
// work per request: the root m, a clear of the window, a base sieve over 1..m
//   that strikes multiples and stores each base prime, a second clear, then per
//   window of m numbers a pass over the base primes that strikes their multiples
//   and a scan that counts and clears the unmarked bits
// work for large limits is bounded by the single write port of the window bit
//   memory (one strike or one clear per cycle)
// the result sits in an output register; a stalled rsp holds the beat, and the
//   block takes the next limit while that beat still waits
// synchronous reset returns to idle with no result pending; memories are not
//   cleared by reset, each request clears the window bits it uses
`default_nettype none

module segmented_prime_count_sieve
   import spcs_pkg::*;
#(
   parameter longint unsigned MAX_LIMIT       = SPCS_MAX_LIMIT,
   parameter int unsigned     WINDOW_SIZE     = SPCS_WINDOW_SIZE,
   parameter int unsigned     MAX_BASE_PRIMES = SPCS_MAX_BASE_PRIMES
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,   // [20:0] upper_limit
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata    // [16:0] prime_count
);

   localparam int unsigned WA_W  = $clog2(WINDOW_SIZE);
   localparam int unsigned PR_W  = $clog2(WINDOW_SIZE + 1);
   localparam int unsigned BA_W  = (MAX_BASE_PRIMES > 1) ? $clog2(MAX_BASE_PRIMES) : 1;
   localparam int unsigned TOT_W = $clog2(MAX_BASE_PRIMES + 1);
   localparam int unsigned ENT_W = PR_W + NUM_W;
   localparam longint unsigned CAP_LIMIT =
      longint'(WINDOW_SIZE) * longint'(WINDOW_SIZE) + 2 * longint'(WINDOW_SIZE);
   localparam longint unsigned SAT_LIMIT = (MAX_LIMIT < CAP_LIMIT) ? MAX_LIMIT : CAP_LIMIT;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_ROOT     = 12'b0000_0000_0010,
      S_CLEAR    = 12'b0000_0000_0100,
      S_BS_READ  = 12'b0000_0000_1000,
      S_BS_TEST  = 12'b0000_0001_0000,
      S_BS_MARK  = 12'b0000_0010_0000,
      S_WIN      = 12'b0000_0100_0000,
      S_SEG_READ = 12'b0000_1000_0000,
      S_SEG_LOAD = 12'b0001_0000_0000,
      S_SEG_MARK = 12'b0010_0000_0000,
      S_SCAN     = 12'b0100_0000_0000,
      S_DONE     = 12'b1000_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [NUM_W-1:0]   n_ff, n_in;
   logic [PR_W-1:0]    m_ff, m_in;
   logic [PR_W:0]      i_ff, i_in;
   logic [NUM_W-1:0]   x_ff, x_in;
   logic [PR_W-1:0]    p_ff, p_in;
   logic [NUM_W-1:0]   w_ff, w_in;
   logic [NUM_W-1:0]   last_ff, last_in;
   logic [WA_W-1:0]    a_ff, a_in;
   logic [WA_W-1:0]    end_ff, end_in;
   logic [TOT_W-1:0]   k_ff, k_in;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               scan_pend_ff, scan_pend_in;
   logic               seg_phase_ff, seg_phase_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [NUM_W-1:0]   n_sat;
   logic [NUM_W-1:0]   win_last;
   logic               accept;
   logic               root_start;
   logic               root_done;
   logic [NUM_W-1:0]   root_value;

   logic               win_mem [WINDOW_SIZE];
   logic               win_we, win_wd, win_rdata;
   logic [WA_W-1:0]    win_wa, win_ra;

   logic [ENT_W-1:0]   base_mem [MAX_BASE_PRIMES];
   logic               base_we;
   logic [BA_W-1:0]    base_wa, base_ra;
   logic [ENT_W-1:0]   base_wd, base_rdata;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign root_start = accept && (n_sat >= NUM_W'(2));
   assign win_last   = (w_ff + NUM_W'(m_ff) - NUM_W'(1) > n_ff) ?
                       n_ff : w_ff + NUM_W'(m_ff) - NUM_W'(1);

   always_comb begin
      n_sat = NUM_W'(req_tdata[LIMIT_W-1:0]);
      if (64'(req_tdata[LIMIT_W-1:0]) > SAT_LIMIT) begin
         n_sat = NUM_W'(SAT_LIMIT);
      end
   end

   spcs_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (n_sat),
      .done  (root_done),
      .root  (root_value)
   );

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      i_in         = i_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      w_in         = w_ff;
      last_in      = last_ff;
      a_in         = a_ff;
      end_in       = end_ff;
      k_in         = k_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      seg_phase_in = seg_phase_ff;
      scan_pend_in = (state_ff == S_SCAN);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_count_in = rsp_count_ff;
      win_we       = 1'b0;
      win_wa       = a_ff;
      win_wd       = 1'b0;
      win_ra       = a_ff;
      base_we      = 1'b0;
      base_wa      = k_ff[BA_W-1:0];
      base_wd      = {p_ff, x_ff};
      base_ra      = k_ff[BA_W-1:0];

      // unmarked bit from the scan read of the previous cycle
      if (scan_pend_ff && !win_rdata) begin
         count_in = count_ff + COUNT_W'(1);
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               n_in     = n_sat;
               count_in = '0;
               total_in = '0;
               state_in = (n_sat < NUM_W'(2)) ? S_DONE : S_ROOT;
            end
         end
         S_ROOT: begin
            if (root_done) begin
               m_in         = PR_W'(root_value);
               end_in       = WA_W'(root_value - NUM_W'(1));
               a_in         = '0;
               seg_phase_in = 1'b0;
               state_in     = S_CLEAR;
            end
         end
         S_CLEAR: begin
            win_we = 1'b1;
            win_wa = a_ff;
            win_wd = 1'b0;
            a_in   = a_ff + WA_W'(1);
            if (a_ff == end_ff) begin
               if (seg_phase_ff) begin
                  w_in     = NUM_W'(m_ff) + NUM_W'(1);
                  state_in = S_WIN;
               end else begin
                  i_in     = (PR_W + 1)'(2);
                  state_in = S_BS_READ;
               end
            end
         end
         S_BS_READ: begin
            win_ra = WA_W'(i_ff - (PR_W + 1)'(1));
            if (i_ff > (PR_W + 1)'(m_ff)) begin
               a_in         = '0;
               seg_phase_in = 1'b1;
               state_in     = S_CLEAR;
            end else begin
               state_in = S_BS_TEST;
            end
         end
         S_BS_TEST: begin
            if (win_rdata) begin
               i_in     = i_ff + (PR_W + 1)'(1);
               state_in = S_BS_READ;
            end else begin
               count_in = count_ff + COUNT_W'(1);
               x_in     = NUM_W'(i_ff) << 1;
               state_in = S_BS_MARK;
            end
         end
         S_BS_MARK: begin
            if (x_ff <= NUM_W'(m_ff)) begin
               win_we = 1'b1;
               win_wa = WA_W'(x_ff - NUM_W'(1));
               win_wd = 1'b1;
               x_in   = x_ff + NUM_W'(i_ff);
            end else begin
               if (total_ff < TOT_W'(MAX_BASE_PRIMES)) begin
                  base_we  = 1'b1;
                  base_wa  = total_ff[BA_W-1:0];
                  base_wd  = {PR_W'(i_ff), x_ff};
                  total_in = total_ff + TOT_W'(1);
               end
               i_in     = i_ff + (PR_W + 1)'(1);
               state_in = S_BS_READ;
            end
         end
         S_WIN: begin
            if (w_ff > n_ff) begin
               state_in = S_DONE;
            end else begin
               last_in  = win_last;
               end_in   = WA_W'(win_last - w_ff);
               k_in     = '0;
               state_in = S_SEG_READ;
            end
         end
         S_SEG_READ: begin
            if (k_ff == total_ff) begin
               a_in     = '0;
               state_in = S_SCAN;
            end else begin
               state_in = S_SEG_LOAD;
            end
         end
         S_SEG_LOAD: begin
            p_in     = base_rdata[ENT_W-1:NUM_W];
            x_in     = base_rdata[NUM_W-1:0];
            state_in = S_SEG_MARK;
         end
         S_SEG_MARK: begin
            if (x_ff <= last_ff) begin
               win_we = 1'b1;
               win_wa = WA_W'(x_ff - w_ff);
               win_wd = 1'b1;
               x_in   = x_ff + NUM_W'(p_ff);
            end else begin
               base_we  = 1'b1;
               base_wa  = k_ff[BA_W-1:0];
               base_wd  = {p_ff, x_ff};
               k_in     = k_ff + TOT_W'(1);
               state_in = S_SEG_READ;
            end
         end
         S_SCAN: begin
            // read and clear in the same cycle, read returns the old bit
            win_ra = a_ff;
            win_we = 1'b1;
            win_wa = a_ff;
            win_wd = 1'b0;
            a_in   = a_ff + WA_W'(1);
            if (a_ff == end_ff) begin
               w_in     = w_ff + NUM_W'(m_ff);
               state_in = S_WIN;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_pend_ff <= scan_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      m_ff         <= m_in;
      i_ff         <= i_in;
      x_ff         <= x_in;
      p_ff         <= p_in;
      w_ff         <= w_in;
      last_ff      <= last_in;
      a_ff         <= a_in;
      end_ff       <= end_in;
      k_ff         <= k_in;
      total_ff     <= total_in;
      count_ff     <= count_in;
      seg_phase_ff <= seg_phase_in;
      rsp_count_ff <= rsp_count_in;
   end

   // window bit memory
   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_wa] <= win_wd;
      end
      win_rdata <= win_mem[win_ra];
   end

   // base prime memory: prime and next multiple per entry
   always_ff @(posedge clock) begin
      if (base_we) begin
         base_mem[base_wa] <= base_wd;
      end
      base_rdata <= base_mem[base_ra];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_count_ff);

endmodule

`default_nettype wire

@@ design/spcs_checker.sv @@
// port-level checks for the segmented prime count sieve, bound to the top level
// depends on spcs_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module spcs_checker
   import spcs_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic [REQ_W-1:0] req_tdata,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata
);

   logic [LIMIT_W-1:0] last_limit;
   logic               small_beat;

   assign last_limit = req_tdata[LIMIT_W-1:0];
   assign small_beat = req_tvalid && req_tready && (last_limit < LIMIT_W'(2));

   `SPCS_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `SPCS_ASSERT_NXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   `SPCS_ASSERT_IMP(a_count_range, rsp_tvalid, rsp_tdata[COUNT_W-1:0] <= COUNT_W'(82025))
   `SPCS_ASSERT_NXT(a_small_limit, small_beat, !rsp_tvalid || $past(rsp_tvalid))

endmodule

bind segmented_prime_count_sieve spcs_checker u_spcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// testbench for segmented_prime_count_sieve: limits go in on req, prime counts come back on rsp
// each count is checked against a segmented sieve predictor kept in this file
// depends on spcs_pkg and the design files

module testbench;
   import spcs_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   // predictor state
   bit strike_map [SPCS_WINDOW_SIZE];
   logic [10:0] sieve_primes [SPCS_MAX_BASE_PRIMES];
   logic [LIMIT_W-1:0] sieve_next [SPCS_MAX_BASE_PRIMES];
   int unsigned sieve_prime_total;
   logic [COUNT_W-1:0] prime_tally;

   logic [COUNT_W-1:0] expected_counts [$];
   logic [COUNT_W-1:0] wanted_count;
   int unsigned limits_sent = 0;
   int unsigned counts_checked = 0;
   int unsigned error_count = 0;
   int unsigned widest_limit = 0;
   int unsigned sender_burst_left = 1;
   bit req_held = 1'b0;
   logic [15:0] stall_pattern = 16'hffff;
   int unsigned stall_phase = 0;

   segmented_prime_count_sieve dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint unsigned int_root(input longint unsigned v);
      longint unsigned r, b, rest;
      r = 0;
      rest = v;
      b = 64'd1 << 40;
      while (b > rest) b >>= 2;
      while (b != 0) begin
         if (rest >= r + b) begin
            rest -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] count_primes_upto(input int unsigned limit);
      longint unsigned n, root, lo, hi, x, y, cap;
      int unsigned k;
      n = 64'(limit) & 64'h1f_ffff;
      cap = longint'(SPCS_WINDOW_SIZE) * SPCS_WINDOW_SIZE + 2 * SPCS_WINDOW_SIZE;
      if (n > SPCS_MAX_LIMIT) n = SPCS_MAX_LIMIT;
      if (n > cap) n = cap;
      prime_tally = '0;
      sieve_prime_total = 0;
      if (n < 2) return '0;
      root = int_root(n);

      // base sieve over 1..root, number x in bit x-1
      for (x = 0; x < SPCS_WINDOW_SIZE; x++) strike_map[x] = 1'b0;
      for (x = 2; x <= root; x++) begin
         if (x - 1 >= SPCS_WINDOW_SIZE || !strike_map[x - 1]) begin
            prime_tally++;
            y = 2 * x;
            while (y <= root) begin
               if (y - 1 < SPCS_WINDOW_SIZE) strike_map[y - 1] = 1'b1;
               y += x;
            end
            if (sieve_prime_total < SPCS_MAX_BASE_PRIMES) begin
               sieve_primes[sieve_prime_total] = 11'(x);
               sieve_next[sieve_prime_total] = LIMIT_W'(y);
               sieve_prime_total++;
            end
         end
      end

      // windows of root numbers from root+1 up to n
      for (lo = root + 1; lo <= n; lo += root) begin
         hi = (lo + root - 1 > n) ? n : lo + root - 1;
         for (x = 0; x < root && x < SPCS_WINDOW_SIZE; x++) strike_map[x] = 1'b0;
         for (k = 0; k < sieve_prime_total; k++) begin
            y = 64'(sieve_next[k]);
            while (y <= hi) begin
               if (y - lo < SPCS_WINDOW_SIZE) strike_map[y - lo] = 1'b1;
               y += 64'(sieve_primes[k]);
            end
            sieve_next[k] = LIMIT_W'(y);
         end
         for (x = lo; x <= hi; x++)
            if (x - lo < SPCS_WINDOW_SIZE && !strike_map[x - lo]) prime_tally++;
      end
      return prime_tally;
   endfunction

   // receiver stalls on a rotating pattern, reloaded now and then
   always @(posedge clock) begin
      if (stall_phase == 0) begin
         stall_phase <= $urandom_range(50, 400);
         stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom) | 16'h0001;
      end else begin
         stall_phase <= stall_phase - 1;
         stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end
      rsp_tready <= stall_pattern[0];
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_counts.size() == 0) begin
            $display("%0t: count beat with none expected, expected none actual %0d",
                     $time, rsp_tdata[COUNT_W-1:0]);
            error_count++;
         end else begin
            wanted_count = expected_counts.pop_front();
            counts_checked++;
            if (rsp_tdata[COUNT_W-1:0] !== wanted_count) begin
               $display("%0t: prime_count mismatch, expected %0d actual %0d",
                        $time, wanted_count, rsp_tdata[COUNT_W-1:0]);
               error_count++;
            end
         end
      end
   end

   task automatic send_limit(input int unsigned limit);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'(limit);
      req_held = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_counts = {expected_counts, count_primes_upto(limit)};
      limits_sent++;
      if (limit > widest_limit) widest_limit = limit;
      if (sender_burst_left > 1) begin
         sender_burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         req_held = 1'b0;
         sender_burst_left = $urandom_range(1, 6);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 3000) : $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic test_small_limits();
      send_limit(0);
      send_limit(1);
      send_limit(2);
      send_limit(3);
      send_limit(4);
      send_limit(5);
      send_limit(8);
      send_limit(9);
      send_limit(10);
   endtask

   // limits around perfect squares move the root and the window size
   task automatic test_square_boundaries();
      send_limit(24);
      send_limit(25);
      send_limit(26);
      send_limit(120);
      send_limit(121);
      send_limit(122);
      send_limit(1023);
      send_limit(1024);
      send_limit(1025);
      send_limit(65535);
      send_limit(65536);
   endtask

   // largest supported limit and an all-ones limit that saturates to it
   task automatic test_clamped_limits();
      send_limit(32'd1048576);
      send_limit(32'h1f_ffff);
   endtask

   task automatic test_random_limits();
      int unsigned pick, root;
      int unsigned limit;
      repeat (80) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            limit = $urandom_range(0, 4096);
         end else if (pick < 82) begin
            limit = $urandom_range(4097, 16384);
         end else if (pick < 87) begin
            limit = $urandom_range(16385, 131072);
         end else begin
            root = $urandom_range(2, 200);
            limit = root * root + $urandom_range(0, 2) - 1;
         end
         send_limit(limit);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_small_limits();
      test_square_boundaries();
      test_clamped_limits();
      test_random_limits();
      if (req_held) req_tvalid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
      $display("sent %0d limits (largest %0d), checked %0d prime counts, %0d mismatches",
               limits_sent, widest_limit, counts_checked, error_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #500_000_000;
      $display("timeout with %0d counts outstanding", expected_counts.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
